@@ src/kstbl_pkg.sv @@
// Package for the keyed statistics hash table: sizes, hash constants,
// operation and status codes, register indexes and the slot row type.
// No dependencies.
package kstbl_pkg;

   // Slot count; a power of two between 16 and 8192.
   localparam int TABLE_SLOTS  = 8192;
   localparam int SLOT_W       = $clog2(TABLE_SLOTS);
   localparam int LOAD_DIVISOR = 8;
   localparam int LOAD_LIMIT   = TABLE_SLOTS - TABLE_SLOTS / LOAD_DIVISOR;
   localparam int USED_W       = $clog2(LOAD_LIMIT + 1);

   // Multiplicative hash: start slot is the top bits of key * HASH_MULT.
   localparam logic [63:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
   localparam int          HASH_SHIFT = 51;
   localparam int          HASH_W     = 64 - HASH_SHIFT;

   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_BIND   = 2'd0;
   localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAW   = 2'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd3;

   localparam int STAT_W = 2;
   localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] STAT_IGNORED   = 2'd3;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_STATS_ENABLE      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_TRACK_ENABLE = 1'd1;

   typedef struct packed {
      logic [63:0] key;
      logic [63:0] hash;
      logic [63:0] draws;
      logic [63:0] volume;
      logic        seen;
   } slot_row_type;

endpackage

@@ src/keyed_stats_hash_table.sv @@
// Flow: bind, ignored requests and lookups of key zero go straight from acceptance to S_FIN;
// record, draw and lookup first hash in S_MUL (one 32x32 multiplier reused over three
// partial products), then take S_READ and S_CHECK per probed slot (registered slot memory
// read) before S_FIN, which waits for the response register to be free. One request at a time:
// a new request is taken only once the last one's response is registered.
// Reset: synchronous; a clearing pass then zeroes all TABLE_SLOTS rows, one per cycle,
// before the first request is accepted. CSR writes are taken throughout.
// Depends on kstbl_pkg.
module keyed_stats_hash_table
   import kstbl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_wdata,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_op,
   input  logic [63:0]          req_shader_key,
   input  logic [63:0]          req_blob_hash,
   input  logic [63:0]          req_draw_volume,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [63:0]          rsp_hash_value,
   output logic                 rsp_first_draw,
   output logic [63:0]          rsp_draw_total,
   output logic [63:0]          rsp_volume_total
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;

   localparam logic [1:0] MUL_LAST = 2'd2;

   // control state
   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] clr_idx_ff, clr_idx_in;
   logic [1:0]        step_ff, step_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [63:0]       current_key_ff, current_key_in;
   logic              stats_en_ff, stats_en_in;
   logic              track_en_ff, track_en_in;
   logic              wr_pend_ff, wr_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [OP_W-1:0]   op_ff, op_in;
   logic [63:0]       key_ff, key_in;
   logic [63:0]       blob_ff, blob_in;
   logic [63:0]       vol_ff, vol_in;
   logic [63:0]       acc_ff, acc_in;
   logic [SLOT_W-1:0] slot_idx_ff, slot_idx_in;
   slot_row_type      wr_row_ff, wr_row_in;
   slot_row_type      rd_row_ff;
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   logic [63:0]       res_hash_ff, res_hash_in;
   logic              res_first_ff, res_first_in;
   logic [63:0]       res_draws_ff, res_draws_in;
   logic [63:0]       res_vol_ff, res_vol_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [63:0]       rsp_hash_ff, rsp_hash_in;
   logic              rsp_first_ff, rsp_first_in;
   logic [63:0]       rsp_draws_ff, rsp_draws_in;
   logic [63:0]       rsp_vol_ff, rsp_vol_in;

   slot_row_type      slot_mem [TABLE_SLOTS];

   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   slot_row_type      mem_wdata;

   logic [31:0]       mul_a, mul_b;
   logic [63:0]       mul_p;
   logic [HASH_W-1:0] hash_top;
   logic              hit, empty, out_free, req_fire;
   slot_row_type      base_row, new_row;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // shared multiplier: low 64 bits of key * HASH_MULT from three partial products
   always_comb begin
      mul_a = (step_ff == MUL_LAST) ? key_ff[63:32] : key_ff[31:0];
      mul_b = (step_ff == 2'd1) ? HASH_MULT[63:32] : HASH_MULT[31:0];
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   assign hash_top = acc_in[63:HASH_SHIFT];

   always_comb begin
      hit   = (rd_row_ff.key == key_ff);
      empty = (rd_row_ff.key == 64'd0);
      if (hit) begin
         base_row = rd_row_ff;
      end else begin
         base_row        = '0;
         base_row.key    = key_ff;
      end
      new_row = base_row;
      if (op_ff == OP_RECORD) begin
         new_row.hash = blob_ff;
      end
      if (op_ff == OP_DRAW) begin
         new_row.draws  = base_row.draws + 64'd1;
         new_row.volume = base_row.volume + vol_ff;
         new_row.seen   = 1'b1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_idx_in     = clr_idx_ff;
      step_in        = step_ff;
      used_in        = used_ff;
      current_key_in = current_key_ff;
      stats_en_in    = stats_en_ff;
      track_en_in    = track_en_ff;
      wr_pend_in     = wr_pend_ff;
      rsp_valid_in   = rsp_valid_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      blob_in        = blob_ff;
      vol_in         = vol_ff;
      acc_in         = acc_ff;
      slot_idx_in    = slot_idx_ff;
      wr_row_in      = wr_row_ff;
      res_status_in  = res_status_ff;
      res_hash_in    = res_hash_ff;
      res_first_in   = res_first_ff;
      res_draws_in   = res_draws_ff;
      res_vol_in     = res_vol_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_hash_in    = rsp_hash_ff;
      rsp_first_in   = rsp_first_ff;
      rsp_draws_in   = rsp_draws_ff;
      rsp_vol_in     = rsp_vol_ff;
      mem_we         = 1'b0;
      mem_waddr      = slot_idx_ff;
      mem_wdata      = wr_row_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_STATS_ENABLE:      stats_en_in = csr_wdata;
            CSR_HASH_TRACK_ENABLE: track_en_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '0;
            clr_idx_in = clr_idx_ff + SLOT_W'(1);
            if (clr_idx_ff == SLOT_W'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in         = req_op;
               key_in        = (req_op == OP_DRAW) ? current_key_ff : req_shader_key;
               blob_in       = req_blob_hash;
               vol_in        = req_draw_volume;
               step_in       = 2'd0;
               wr_pend_in    = 1'b0;
               res_status_in = STAT_IGNORED;
               res_hash_in   = 64'd0;
               res_first_in  = 1'b0;
               res_draws_in  = 64'd0;
               res_vol_in    = 64'd0;
               state_in      = S_FIN;
               unique case (req_op)
                  OP_BIND: begin
                     current_key_in = req_shader_key;
                     res_status_in  = STAT_DONE;
                  end
                  OP_RECORD: begin
                     if (track_en_ff && req_shader_key != 64'd0) begin
                        state_in = S_MUL;
                     end
                  end
                  OP_DRAW: begin
                     if (stats_en_ff && current_key_ff != 64'd0) begin
                        state_in = S_MUL;
                     end
                  end
                  OP_LOOKUP: begin
                     if (req_shader_key != 64'd0) begin
                        state_in = S_MUL;
                     end else begin
                        res_status_in = STAT_NOT_FOUND;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            acc_in  = (step_ff == 2'd0) ? mul_p : acc_ff + {mul_p[31:0], 32'd0};
            step_in = step_ff + 2'd1;
            if (step_ff == MUL_LAST) begin
               slot_idx_in = hash_top[SLOT_W-1:0];
               state_in    = S_READ;
            end
         end
         S_READ: begin
            // row at slot_idx_ff lands in rd_row_ff at this edge
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (hit || empty) begin
               state_in = S_FIN;
               if (op_ff == OP_LOOKUP) begin
                  res_status_in = hit ? STAT_DONE : STAT_NOT_FOUND;
                  res_hash_in   = hit ? rd_row_ff.hash : 64'd0;
               end else if (empty && used_ff >= USED_W'(LOAD_LIMIT)) begin
                  res_status_in = STAT_FULL;
               end else begin
                  wr_row_in     = new_row;
                  wr_pend_in    = 1'b1;
                  res_status_in = STAT_DONE;
                  if (empty) begin
                     used_in = used_ff + USED_W'(1);
                  end
                  if (op_ff == OP_DRAW) begin
                     res_first_in = !base_row.seen;
                     res_draws_in = new_row.draws;
                     res_vol_in   = new_row.volume;
                  end
               end
            end else begin
               // advance to the next slot, wrapping at the end
               slot_idx_in = (slot_idx_ff == SLOT_W'(TABLE_SLOTS - 1)) ?
                             '0 : slot_idx_ff + SLOT_W'(1);
               state_in    = S_READ;
            end
         end
         S_FIN: begin
            if (out_free) begin
               mem_we        = wr_pend_ff;
               wr_pend_in    = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_hash_in   = res_hash_ff;
               rsp_first_in  = res_first_ff;
               rsp_draws_in  = res_draws_ff;
               rsp_vol_in    = res_vol_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_idx_ff     <= '0;
         step_ff        <= '0;
         used_ff        <= '0;
         current_key_ff <= '0;
         stats_en_ff    <= 1'b0;
         track_en_ff    <= 1'b0;
         wr_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         step_ff        <= step_in;
         used_ff        <= used_in;
         current_key_ff <= current_key_in;
         stats_en_ff    <= stats_en_in;
         track_en_ff    <= track_en_in;
         wr_pend_ff     <= wr_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      blob_ff       <= blob_in;
      vol_ff        <= vol_in;
      acc_ff        <= acc_in;
      slot_idx_ff   <= slot_idx_in;
      wr_row_ff     <= wr_row_in;
      res_status_ff <= res_status_in;
      res_hash_ff   <= res_hash_in;
      res_first_ff  <= res_first_in;
      res_draws_ff  <= res_draws_in;
      res_vol_ff    <= res_vol_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hash_ff   <= rsp_hash_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_draws_ff  <= rsp_draws_in;
      rsp_vol_ff    <= rsp_vol_in;
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_row_ff <= slot_mem[slot_idx_ff];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_hash_value   = rsp_hash_ff;
   assign rsp_first_draw   = rsp_first_ff;
   assign rsp_draw_total   = rsp_draws_ff;
   assign rsp_volume_total = rsp_vol_ff;

endmodule

@@ sim/tb_top.sv @@
// Testbench for keyed_stats_hash_table: random and directed requests against an
// in-bench model of the probing table, checked response by response.
// Depends on kstbl_pkg and the keyed_stats_hash_table RTL.
module tb_top
   import kstbl_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 60000;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [63:0]       hash_value;
      logic              first_draw;
      logic [63:0]       draw_total;
      logic [63:0]       volume_total;
   } table_reply_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_STATS_ENABLE;
   logic                 csr_wdata = 1'b0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_op = OP_BIND;
   logic [63:0]          req_shader_key = '0;
   logic [63:0]          req_blob_hash = '0;
   logic [63:0]          req_draw_volume = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STAT_W-1:0]    rsp_status;
   logic [63:0]          rsp_hash_value;
   logic                 rsp_first_draw;
   logic [63:0]          rsp_draw_total;
   logic [63:0]          rsp_volume_total;

   // Mirror of the table contents and configuration.
   bit [63:0] tbl_key    [TABLE_SLOTS];
   bit [63:0] tbl_hash   [TABLE_SLOTS];
   bit [63:0] tbl_draws  [TABLE_SLOTS];
   bit [63:0] tbl_volume [TABLE_SLOTS];
   bit        tbl_seen   [TABLE_SLOTS];
   bit [63:0] bound_key;
   int        used_slots;
   bit        stats_on;
   bit        hash_track_on;

   table_reply_type pending_replies[$];
   table_reply_type want;
   logic [63:0]     key_pool[$];
   int              fault_count;
   int              stall_cycles;
   int              send_idle_pct;
   int              recv_idle_pct;
   bit              valid_held;

   keyed_stats_hash_table u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_shader_key   (req_shader_key),
      .req_blob_hash    (req_blob_hash),
      .req_draw_volume  (req_draw_volume),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_hash_value   (rsp_hash_value),
      .rsp_first_draw   (rsp_first_draw),
      .rsp_draw_total   (rsp_draw_total),
      .rsp_volume_total (rsp_volume_total)
   );

   always #4 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int unsigned home_slot(input logic [63:0] key);
      logic [63:0] prod;
      prod = key * HASH_MULT;
      return int'((prod >> HASH_SHIFT) % TABLE_SLOTS);
   endfunction

   // Nonzero random key whose probe starts at the given slot.
   function automatic logic [63:0] find_key_at(input int unsigned slot);
      logic [63:0] k;
      k = rand64();
      while (k == 64'd0 || home_slot(k) != slot) k = rand64();
      return k;
   endfunction

   // Walk upward from the home slot; claim the first free slot when inserting
   // and the table is below its load limit.
   function automatic int locate_slot(input logic [63:0] key, input bit insert);
      int unsigned base;
      int unsigned idx;
      base = home_slot(key);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         idx = (base + i) % TABLE_SLOTS;
         if (tbl_key[idx] == key) return int'(idx);
         if (tbl_key[idx] == 64'd0) begin
            if (!insert || used_slots >= LOAD_LIMIT) return -1;
            tbl_key[idx] = key;
            used_slots++;
            return int'(idx);
         end
      end
      return -1;
   endfunction

   function automatic table_reply_type apply_table_request(input logic [OP_W-1:0] op,
                                                          input logic [63:0] key,
                                                          input logic [63:0] blob,
                                                          input logic [63:0] volume);
      table_reply_type reply;
      int s;
      reply = '0;
      reply.status = STAT_IGNORED;
      case (op)
         OP_BIND: begin
            bound_key = key;
            reply.status = STAT_DONE;
         end
         OP_RECORD: begin
            if (hash_track_on && key != 64'd0) begin
               s = locate_slot(key, 1'b1);
               if (s < 0) reply.status = STAT_FULL;
               else begin
                  tbl_hash[s] = blob;
                  reply.status = STAT_DONE;
               end
            end
         end
         OP_DRAW: begin
            if (stats_on && bound_key != 64'd0) begin
               s = locate_slot(bound_key, 1'b1);
               if (s < 0) reply.status = STAT_FULL;
               else begin
                  tbl_draws[s] = tbl_draws[s] + 64'd1;
                  tbl_volume[s] = tbl_volume[s] + volume;
                  reply.first_draw = !tbl_seen[s];
                  tbl_seen[s] = 1'b1;
                  reply.draw_total = tbl_draws[s];
                  reply.volume_total = tbl_volume[s];
                  reply.status = STAT_DONE;
               end
            end
         end
         default: begin
            s = (key != 64'd0) ? locate_slot(key, 1'b0) : -1;
            if (s < 0) reply.status = STAT_NOT_FOUND;
            else begin
               reply.hash_value = tbl_hash[s];
               reply.status = STAT_DONE;
            end
         end
      endcase
      return reply;
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [63:0] key,
                               input logic [63:0] blob, input logic [63:0] volume);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         if (valid_held) begin
            req_valid <= 1'b0;
            valid_held = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_shader_key  <= key;
      req_blob_hash   <= blob;
      req_draw_volume <= volume;
      valid_held = 1'b1;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      pending_replies.push_back(apply_table_request(op, key, blob, volume));
   endtask

   // Drop valid and hold until every outstanding response is back.
   task automatic wait_all_results();
      if (valid_held) begin
         req_valid <= 1'b0;
         valid_held = 1'b0;
         @(posedge clock);
      end
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input bit stats, input bit track);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_STATS_ENABLE;
      csr_wdata <= stats;
      @(posedge clock);
      csr_index <= CSR_HASH_TRACK_ENABLE;
      csr_wdata <= track;
      @(posedge clock);
      csr_we <= 1'b0;
      stats_on = stats;
      hash_track_on = track;
   endtask

   task automatic test_special_cases();
      set_config(1'b0, 1'b0);
      send_request(OP_LOOKUP, 64'd0, '1, '1);
      send_request(OP_RECORD, '1, '1, '0);
      send_request(OP_DRAW, '1, '0, '1);
      send_request(OP_BIND, '1, '0, '0);
      send_request(OP_DRAW, '0, '0, '1);
      wait_all_results();
      set_config(1'b1, 1'b1);
      send_request(OP_RECORD, 64'd0, 64'hDEAD_BEEF_0BAD_F00D, '0);
      send_request(OP_RECORD, '1, '1, '0);
      send_request(OP_LOOKUP, '1, '0, '0);
      send_request(OP_LOOKUP, 64'd1, '0, '0);
      // two draws on the same key: the second wraps the volume
      send_request(OP_DRAW, '0, '0, '1);
      send_request(OP_DRAW, '0, '0, 64'd2);
      send_request(OP_BIND, 64'd0, '0, '0);
      send_request(OP_DRAW, '0, '0, 64'd7);
      send_request(OP_BIND, 64'h8000_0000_0000_0000, '0, '0);
      send_request(OP_DRAW, '0, '0, 64'd0);
      send_request(OP_LOOKUP, 64'h8000_0000_0000_0000, '0, '0);
      send_request(OP_RECORD, 64'h8000_0000_0000_0000, 64'h5A5A_A5A5_0F0F_F0F0, '0);
      send_request(OP_LOOKUP, 64'h8000_0000_0000_0000, '0, '0);
   endtask

   // Keys sharing the last home slot force the probe to wrap to slot zero.
   task automatic test_probe_wrap();
      logic [63:0] key_a, key_b, key_c, key_d;
      key_a = find_key_at(TABLE_SLOTS - 1);
      key_b = find_key_at(TABLE_SLOTS - 1);
      key_c = find_key_at(TABLE_SLOTS - 1);
      key_d = find_key_at(TABLE_SLOTS - 1);
      send_request(OP_RECORD, key_a, rand64(), '0);
      send_request(OP_RECORD, key_b, rand64(), '0);
      send_request(OP_RECORD, key_c, rand64(), '0);
      send_request(OP_BIND, key_c, '0, '0);
      send_request(OP_DRAW, '0, '0, rand64());
      send_request(OP_LOOKUP, key_b, '0, '0);
      send_request(OP_LOOKUP, key_d, '0, '0);
   endtask

   task automatic test_random_traffic(input int count);
      logic [OP_W-1:0] op;
      logic [63:0]     key;
      logic [63:0]     volume;
      int              pick;
      if (key_pool.size() == 0) begin
         for (int i = 0; i < 40; i++) key_pool.push_back(rand64());
         for (int i = 0; i < 6; i++) key_pool.push_back(find_key_at(home_slot(key_pool[0])));
         key_pool.push_back('1);
         key_pool.push_back(64'd1);
         key_pool.push_back(64'h8000_0000_0000_0000);
         key_pool.push_back(find_key_at(TABLE_SLOTS - 1));
      end
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 20) op = OP_BIND;
         else if (pick < 45) op = OP_RECORD;
         else if (pick < 80) op = OP_DRAW;
         else op = OP_LOOKUP;
         pick = $urandom_range(99);
         if (pick < 78) key = key_pool[$urandom_range(key_pool.size() - 1)];
         else if (pick < 94) key = rand64();
         else key = 64'd0;
         volume = ($urandom_range(7) == 0) ? rand64() : 64'($urandom_range(5000));
         if (n == count / 2) wait_all_results();
         send_request(op, key, rand64(), volume);
      end
   endtask

   // Switch the enables around an anchor key; ignored requests leave its entry alone.
   task automatic test_enable_switch();
      logic [63:0] anchor;
      anchor = rand64() | 64'd1;
      send_request(OP_RECORD, anchor, rand64(), '0);
      send_request(OP_RECORD, anchor, rand64(), '0);
      send_request(OP_LOOKUP, anchor, '0, '0);
      send_request(OP_LOOKUP, rand64() | 64'd1, '0, '0);
      send_request(OP_BIND, rand64() | 64'd1, '0, '0);
      send_request(OP_DRAW, '0, '0, rand64());
      send_request(OP_BIND, anchor, '0, '0);
      send_request(OP_DRAW, '0, '0, rand64());
      test_random_traffic(150);
      wait_all_results();
      set_config(1'b0, 1'b1);
      send_request(OP_DRAW, '0, '0, rand64());
      send_request(OP_RECORD, rand64() | 64'd1, rand64(), '0);
      wait_all_results();
      set_config(1'b1, 1'b0);
      send_request(OP_RECORD, anchor, rand64(), '0);
      send_request(OP_DRAW, '0, '0, rand64());
   endtask

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) $display("unexpected response, status %0d", rsp_status);
         end else begin
            want = pending_replies.pop_front();
            if ({rsp_status, rsp_hash_value, rsp_first_draw, rsp_draw_total,
                 rsp_volume_total} !== want) begin
               fault_count++;
               if (fault_count <= 10)
                  $display({"mismatch exp/act: status %0d/%0d hash %h/%h first %0d/%0d",
                            " draws %h/%h volume %h/%h"},
                           want.status, rsp_status, want.hash_value, rsp_hash_value,
                           want.first_draw, rsp_first_draw, want.draw_total,
                           rsp_draw_total, want.volume_total, rsp_volume_total);
            end
         end
      end
   end

   // Abort when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      send_idle_pct = 37;
      recv_idle_pct = 51;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_probe_wrap();
      test_random_traffic(200);
      wait_all_results();
      set_config(1'b0, 1'b1);
      test_random_traffic(200);
      wait_all_results();
      send_idle_pct = 51;
      recv_idle_pct = 37;
      set_config(1'b1, 1'b0);
      test_random_traffic(200);
      wait_all_results();
      set_config(1'b1, 1'b1);
      test_random_traffic(200);
      wait_all_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(1'b0, 1'b0);
      test_random_traffic(100);
      wait_all_results();
      set_config(1'b1, 1'b1);
      test_random_traffic(150);
      wait_all_results();
      test_enable_switch();
      wait_all_results();
      repeat (20) @(posedge clock);
      if (pending_replies.size() != 0) fault_count++;
      if (fault_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ files.f @@
src/kstbl_pkg.sv
src/keyed_stats_hash_table.sv
sim/tb_top.sv
